// ----- hdl/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, constants and calendar tables of the date text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

	localparam int        YEAR_DIGITS_DEF = 4;
	localparam int        CHAR_W          = 8;
	localparam int        DAY_W           = 7;
	localparam int        YEAR_W          = 14;
	localparam int        WEEK_W          = 3;

	localparam logic [7:0] SEP_RESET  = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [6:0] FIELD_MAX  = 7'd99;

	// Final values of one date text, taken when the last character arrives.
	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [DAY_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic              ok;
	} dtp_snap_t;

	// The same values plus year / 100 and year % 100.
	typedef struct packed {
		dtp_snap_t  snap;
		logic [7:0] cent;
		logic [6:0] rem;
	} dtp_split_t;

	// Largest year that fits the given digit count, held to 14 bits.
	function automatic logic [YEAR_W-1:0] year_limit(input int digits);
		int lim;
		lim = 1;
		for (int i = 0; i < 5; i++) begin
			if (i < digits) begin
				lim = lim * 10;
			end
		end
		lim = lim - 1;
		if (lim > 16383) begin
			lim = 16383;
		end
		return YEAR_W'(lim);
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] month);
		logic [4:0] d;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                       d = 5'd28;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

	// floor(2.6 m - 0.2) for the March-based month m of a civil month.
	function automatic logic [4:0] march_term(input logic [3:0] month);
		logic [4:0] t;
		case (month)
			4'd3:    t = 5'd2;
			4'd4:    t = 5'd5;
			4'd5:    t = 5'd7;
			4'd6:    t = 5'd10;
			4'd7:    t = 5'd12;
			4'd8:    t = 5'd15;
			4'd9:    t = 5'd18;
			4'd10:   t = 5'd20;
			4'd11:   t = 5'd23;
			4'd12:   t = 5'd25;
			4'd1:    t = 5'd28;
			4'd2:    t = 5'd31;
			default: t = 5'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/date_text_parser_weekday.sv -----
// ----------------------------------------------------------------------------
// date_text_parser_weekday
// Parses a day<sep>month<sep>year text one character per request and puts
// out the date, a Gregorian validity flag and the weekday.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload                          Width
//   -------  --------------------  -------------------------------  ------
//   input    in_valid / in_stall   text_char, last_char             8 + 1
//   output   out_valid / out_stall day_number, month_number,        7 + 7
//                                  year_number, week_day,           14 + 3
//                                  date_valid                       1
//   config   cfg_wr_en             cfg_wr_data (separator_char)     8
//
// One character request is taken per cycle while in_stall is low. Only the
// request that carries last_char produces a result; it passes the snapshot
// register, the century split register and the result register, in that
// order, before it shows on the output.
// The result register is backed by the two stages before it, so input keeps
// flowing while a result waits; in_stall rises only when all three hold a
// finished text and out_stall is high.
// Reset puts the parser back in the day field with the separator set to the
// dot; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module date_text_parser_weekday #(
	parameter int YEAR_DIGITS = dtp_pkg::YEAR_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [dtp_pkg::CHAR_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [dtp_pkg::CHAR_W-1:0]    text_char,
	input  wire logic                          last_char,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [dtp_pkg::DAY_W-1:0]          day_number,
	output logic [dtp_pkg::DAY_W-1:0]          month_number,
	output logic [dtp_pkg::YEAR_W-1:0]         year_number,
	output logic [dtp_pkg::WEEK_W-1:0]         week_day,
	output logic                               date_valid
);

	// Each stage may load when it is empty or when the stage after it moves.
	logic                 s1_open;
	logic                 s1_valid;
	dtp_pkg::dtp_snap_t   s1_snap;
	logic                 s2_open;
	logic                 s2_valid;
	dtp_pkg::dtp_split_t  s2_data;
	logic                 out_open;

	assign in_stall = !s1_open;

	// Character parsing and the snapshot of a finished text.
	dtp_parser #(
		.YEAR_DIGITS(YEAR_DIGITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.text_char   (text_char),
		.last_char   (last_char),
		.s2_open     (s2_open),
		.s1_open     (s1_open),
		.s1_valid    (s1_valid),
		.s1_snap     (s1_snap)
	);

	// Century and year of century, needed for the leap test and the weekday.
	dtp_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1_snap  (s1_snap),
		.out_open (out_open),
		.s2_open  (s2_open),
		.s2_valid (s2_valid),
		.s2_data  (s2_data)
	);

	// Calendar check, weekday and the result register.
	dtp_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s2_valid     (s2_valid),
		.s2_data      (s2_data),
		.out_stall    (out_stall),
		.out_open     (out_open),
		.out_valid    (out_valid),
		.day_number   (day_number),
		.month_number (month_number),
		.year_number  (year_number),
		.week_day     (week_day),
		.date_valid   (date_valid)
	);

endmodule

`default_nettype wire

// ----- hdl/dtp_parser.sv -----
// ----------------------------------------------------------------------------
// dtp_parser
// Character parser: day, month and year accumulators, separator checks and
// the snapshot register that hands a finished text to the date check.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_parser #(
	parameter int YEAR_DIGITS = dtp_pkg::YEAR_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [dtp_pkg::CHAR_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	input  wire logic [dtp_pkg::CHAR_W-1:0]    text_char,
	input  wire logic                          last_char,
	input  wire logic                          s2_open,
	output logic                               s1_open,
	output logic                               s1_valid,
	output dtp_pkg::dtp_snap_t                 s1_snap
);

	localparam logic [1:0] PH_DAY   = 2'd0;
	localparam logic [1:0] PH_MONTH = 2'd1;
	localparam logic [1:0] PH_YEAR  = 2'd2;
	localparam logic [dtp_pkg::YEAR_W-1:0] YEAR_LIM = dtp_pkg::year_limit(YEAR_DIGITS);

	function automatic logic [6:0] add_field(input logic [6:0] v, input logic [3:0] d);
		logic [9:0] n;
		n = 10'(v) * 10'd10 + 10'(d);
		return (n > 10'(dtp_pkg::FIELD_MAX)) ? dtp_pkg::FIELD_MAX : n[6:0];
	endfunction

	logic [7:0]  sep_q;
	logic [1:0]  phase_q, phase_n;
	logic [6:0]  day_q, day_n;
	logic [6:0]  month_q, month_n;
	logic [13:0] year_q, year_n;
	logic        sep_ok_q, sep_ok_n;
	logic        over_q, over_n;
	logic        minus_q, minus_n;
	logic        began_q, began_n;
	logic        stopped_q, stopped_n;
	logic        s1_valid_q;
	dtp_pkg::dtp_snap_t snap_s1;

	logic        is_digit;
	logic [3:0]  digit;
	logic [17:0] year_next;
	logic        accept;

	assign is_digit  = (text_char >= dtp_pkg::CHAR_ZERO) && (text_char <= dtp_pkg::CHAR_NINE);
	assign digit     = is_digit ? 4'(text_char - dtp_pkg::CHAR_ZERO) : 4'd0;
	assign year_next = 18'(year_q) * 18'd10 + 18'(digit);

	always_comb begin
		phase_n   = phase_q;
		day_n     = day_q;
		month_n   = month_q;
		year_n    = year_q;
		sep_ok_n  = sep_ok_q;
		over_n    = over_q;
		minus_n   = minus_q;
		began_n   = began_q;
		stopped_n = stopped_q;
		case (phase_q)
			PH_DAY: begin
				if (is_digit) begin
					day_n = add_field(day_q, digit);
				end else begin
					sep_ok_n = sep_ok_q && (text_char == sep_q);
					phase_n  = PH_MONTH;
				end
			end
			PH_MONTH: begin
				if (is_digit) begin
					month_n = add_field(month_q, digit);
				end else begin
					sep_ok_n = sep_ok_q && (text_char == sep_q);
					phase_n  = PH_YEAR;
				end
			end
			PH_YEAR: begin
				if (!stopped_q) begin
					if (is_digit) begin
						began_n = 1'b1;
						if (year_next > 18'(YEAR_LIM)) begin
							over_n = 1'b1;
							year_n = YEAR_LIM;
						end else begin
							year_n = year_next[13:0];
						end
					end else if (!began_q && ((text_char == dtp_pkg::CHAR_PLUS) ||
					                          (text_char == dtp_pkg::CHAR_MINUS))) begin
						began_n = 1'b1;
						minus_n = (text_char == dtp_pkg::CHAR_MINUS);
					end else begin
						stopped_n = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s1_open = !s1_valid_q || s2_open;
	assign accept  = in_valid && s1_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= dtp_pkg::SEP_RESET;
		end else if (cfg_wr_en) begin
			sep_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DAY;
			day_q     <= '0;
			month_q   <= '0;
			year_q    <= '0;
			sep_ok_q  <= 1'b1;
			over_q    <= 1'b0;
			minus_q   <= 1'b0;
			began_q   <= 1'b0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				phase_q   <= PH_DAY;
				day_q     <= '0;
				month_q   <= '0;
				year_q    <= '0;
				sep_ok_q  <= 1'b1;
				over_q    <= 1'b0;
				minus_q   <= 1'b0;
				began_q   <= 1'b0;
				stopped_q <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				day_q     <= day_n;
				month_q   <= month_n;
				year_q    <= year_n;
				sep_ok_q  <= sep_ok_n;
				over_q    <= over_n;
				minus_q   <= minus_n;
				began_q   <= began_n;
				stopped_q <= stopped_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_open) begin
			s1_valid_q <= accept && last_char;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_char) begin
			snap_s1.day   <= day_n;
			snap_s1.month <= month_n;
			snap_s1.year  <= year_n;
			snap_s1.ok    <= sep_ok_n && (phase_n == PH_YEAR) && !over_n &&
			                 !(minus_n && (year_n != '0));
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_snap  = snap_s1;

	// A finished text always restarts the parse in the day field.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_char |=> (phase_q == PH_DAY) && (day_q == '0) && sep_ok_q)
		else $error("parser did not restart after the last character");

	// The year accumulator never passes its limit.
	a_year_lim: assert property (@(posedge clk) disable iff (!arst_n)
		year_q <= YEAR_LIM)
		else $error("year accumulator above its limit");

	// A waiting snapshot is not dropped while the next stage is busy.
	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s2_open |=> s1_valid_q && $stable(snap_s1))
		else $error("snapshot lost while the split stage was busy");

endmodule

`default_nettype wire

// ----- hdl/dtp_split.sv -----
// ----------------------------------------------------------------------------
// dtp_split
// Splits the year into century and year of century with a reciprocal
// multiply by 1/100.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_split (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s1_valid,
	input  wire dtp_pkg::dtp_snap_t   s1_snap,
	input  wire logic                 out_open,
	output logic                      s2_open,
	output logic                      s2_valid,
	output dtp_pkg::dtp_split_t       s2_data
);

	logic [26:0] recip;
	logic [7:0]  cent;
	logic [13:0] cent_x100;
	logic [6:0]  rem;
	logic        s2_valid_q;
	dtp_pkg::dtp_split_t data_s2;

	// 5243 / 2^19 is exact for year / 100 up to 43689.
	assign recip     = 27'(s1_snap.year) * 27'd5243;
	assign cent      = recip[26:19];
	assign cent_x100 = 14'(cent) * 14'd100;
	assign rem       = 7'(s1_snap.year - cent_x100);

	assign s2_open = !s2_valid_q || out_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_open) begin
			s2_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_open && s1_valid) begin
			data_s2.snap <= s1_snap;
			data_s2.cent <= cent;
			data_s2.rem  <= rem;
		end
	end

	assign s2_valid = s2_valid_q;
	assign s2_data  = data_s2;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> (data_s2.rem < 7'd100))
		else $error("year remainder out of range");

	a_split_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && !out_open |=> s2_valid_q && $stable(data_s2))
		else $error("split stage changed while the output was busy");

	a_split_exact: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> (14'(data_s2.cent) * 14'd100 + 14'(data_s2.rem) == data_s2.snap.year))
		else $error("century split does not rebuild the year");

endmodule

`default_nettype wire

// ----- hdl/dtp_check.sv -----
// ----------------------------------------------------------------------------
// dtp_check
// Gregorian date check, weekday by Gauss's formula and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_check (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s2_valid,
	input  wire dtp_pkg::dtp_split_t          s2_data,
	input  wire logic                         out_stall,
	output logic                              out_open,
	output logic                              out_valid,
	output logic [dtp_pkg::DAY_W-1:0]         day_number,
	output logic [dtp_pkg::DAY_W-1:0]         month_number,
	output logic [dtp_pkg::YEAR_W-1:0]        year_number,
	output logic [dtp_pkg::WEEK_W-1:0]        week_day,
	output logic                              date_valid
);

	logic [6:0]  day;
	logic [6:0]  mon;
	logic [3:0]  mon_idx;
	logic        mon_ok;
	logic        leap;
	logic [4:0]  dim;
	logic        valid;
	logic        jan_feb;
	logic [6:0]  yoc;
	logic [7:0]  cc;
	logic [10:0] sum;
	logic [21:0] recip7;
	logic [7:0]  q7;
	logic [2:0]  wk;

	logic        out_valid_q;
	logic [6:0]  day_q;
	logic [6:0]  month_q;
	logic [13:0] year_q;
	logic [2:0]  week_q;
	logic        date_ok_q;

	assign day     = s2_data.snap.day;
	assign mon     = s2_data.snap.month;
	assign mon_idx = mon[3:0];
	assign mon_ok  = mon inside {[7'd1:7'd12]};
	assign leap    = (s2_data.snap.year[1:0] == 2'b00) &&
	                 ((s2_data.rem != 7'd0) || (s2_data.cent[1:0] == 2'b00));
	assign dim     = (mon_idx == 4'd2 && leap) ? 5'd29 : dtp_pkg::month_days(mon_idx);
	assign valid   = s2_data.snap.ok && mon_ok && (day != 7'd0) && (day <= 7'(dim));

	// January and February count in the year before; 400 years are added.
	assign jan_feb = mon inside {7'd1, 7'd2};
	always_comb begin
		if (jan_feb && (s2_data.rem == 7'd0)) begin
			yoc = 7'd99;
			cc  = s2_data.cent + 8'd3;
		end else if (jan_feb) begin
			yoc = s2_data.rem - 7'd1;
			cc  = s2_data.cent + 8'd4;
		end else begin
			yoc = s2_data.rem;
			cc  = s2_data.cent + 8'd4;
		end
	end

	assign sum = 11'(day) + 11'(dtp_pkg::march_term(mon_idx)) + 11'(yoc) +
	             11'(yoc >> 2) + 11'(cc >> 2) + 11'(cc) * 11'd5;

	// 2341 / 2^14 gives sum / 7 exactly for sums below 5460.
	assign recip7 = 22'(sum) * 22'd2341;
	assign q7     = recip7[21:14];
	assign wk     = 3'(sum - 11'(q7) * 11'd7);

	assign out_open = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_open) begin
			out_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_open && s2_valid) begin
			day_q     <= day;
			month_q   <= mon;
			year_q    <= s2_data.snap.year;
			week_q    <= valid ? wk : 3'd0;
			date_ok_q <= valid;
		end
	end

	assign out_valid    = out_valid_q;
	assign day_number   = day_q;
	assign month_number = month_q;
	assign year_number  = year_q;
	assign week_day     = week_q;
	assign date_valid   = date_ok_q;

	a_week_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !date_ok_q |-> (week_q == 3'd0))
		else $error("weekday set on an invalid date");

	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && date_ok_q |-> (month_q >= 7'd1) && (month_q <= 7'd12) &&
		                             (day_q >= 7'd1) && (day_q <= 7'd31) && (week_q <= 3'd6))
		else $error("valid date with fields out of range");

	a_mod7: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid |-> (wk <= 3'd6))
		else $error("weekday remainder out of range");

endmodule

`default_nettype wire

// ----- dv/date_text_parser_weekday_test.sv -----
// ----------------------------------------------------------------------------
// date_text_parser_weekday_test
// Self-checking testbench for the date text parser. Date texts are sent one
// character per request. An in-bench parser predicts each parsed date, its
// validity and its weekday. Every result is compared field by field with the
// oldest pending prediction. Random idle bursts on both channels, and a few
// separator settings, vary the timing and the parsing.
// ----------------------------------------------------------------------------
`default_nettype none

module date_text_parser_weekday_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Largest year the parser accepts for the default digit count.
	localparam int YEAR_MAX = (10 ** dtp_pkg::YEAR_DIGITS_DEF - 1 > 16383) ? 16383 :
		10 ** dtp_pkg::YEAR_DIGITS_DEF - 1;

	// Least number of chars sent per separator setting in the random part.
	localparam int PHASE_CHARS = 180;

	typedef logic [dtp_pkg::CHAR_W-1:0] char_t;

	typedef enum logic [1:0] {
		FLD_DAY,
		FLD_MONTH,
		FLD_YEAR
	} field_t;

	// One parsed date as the block reports it.
	typedef struct packed {
		logic [dtp_pkg::DAY_W-1:0]  day;
		logic [dtp_pkg::DAY_W-1:0]  month;
		logic [dtp_pkg::YEAR_W-1:0] year;
		logic [dtp_pkg::WEEK_W-1:0] wday;
		logic                       ok;
	} date_result_t;

	// All block inputs hold known values from time zero.
	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_wr_en   = 1'b0;
	char_t                       cfg_wr_data = '0;
	logic                        in_valid    = 1'b0;
	char_t                       text_char   = '0;
	logic                        last_char   = 1'b0;
	logic                        out_stall   = 1'b0;

	logic                        in_stall;
	logic                        out_valid;
	logic [dtp_pkg::DAY_W-1:0]   day_number;
	logic [dtp_pkg::DAY_W-1:0]   month_number;
	logic [dtp_pkg::YEAR_W-1:0]  year_number;
	logic [dtp_pkg::WEEK_W-1:0]  week_day;
	logic                        date_valid;

	date_text_parser_weekday dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_char    (text_char),
		.last_char    (last_char),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.day_number   (day_number),
		.month_number (month_number),
		.year_number  (year_number),
		.week_day     (week_day),
		.date_valid   (date_valid)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Parser state kept by the bench. It follows the block one accepted
	// character at a time, using the separator the bench last wrote.
	// ------------------------------------------------------------------------
	char_t             sep_reg    = dtp_pkg::SEP_RESET;
	field_t            field_at   = FLD_DAY;
	int                day_acc    = 0;
	int                month_acc  = 0;
	int                year_acc   = 0;
	bit                seps_good  = 1'b1;
	bit                year_over  = 1'b0;
	bit                year_neg   = 1'b0;
	bit                year_began = 1'b0;
	bit                year_done  = 1'b0;

	// Dates predicted but not yet seen on the output, oldest first.
	date_result_t      dates_due[$];

	// Characters of the text that is about to be sent.
	char_t             text_buf[$];

	int                mismatches = 0;
	int                chars_sent = 0;
	bit                gaps_on    = 1'b0;
	bit                stalls_on  = 1'b0;
	int                stall_left = 0;
	date_result_t      got_date;
	date_result_t      want_date;

	function automatic int month_length(input int m, input int y);
		bit leap;
		leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		case (m)
			2:             return leap ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// Gauss's weekday rule. Months are counted from March, so January and
	// February belong to the year before. Adding 400 years keeps every term
	// nonnegative without moving the weekday, and +5c stands in for -2c.
	function automatic logic [dtp_pkg::WEEK_W-1:0] weekday_of(input int d, input int m,
		input int y);
		int mm, yy, lo, hi, w;
		mm = (m <= 2) ? m + 10 : m - 2;
		yy = y + 400 - ((m <= 2) ? 1 : 0);
		lo = yy % 100;
		hi = yy / 100;
		w  = (d + (26 * mm - 2) / 10 + lo + lo / 4 + hi / 4 + 5 * hi) % 7;
		return w[dtp_pkg::WEEK_W-1:0];
	endfunction

	// Advances the bench parser by one accepted character. On the last
	// character of a text it queues the expected date and starts over.
	task automatic predict_date(input char_t c, input logic fin);
		bit           is_dig;
		int           dv;
		int           n;
		bit           ok;
		date_result_t r;
		is_dig = c inside {[dtp_pkg::CHAR_ZERO:dtp_pkg::CHAR_NINE]};
		dv = int'(c) - int'(dtp_pkg::CHAR_ZERO);
		case (field_at)
			FLD_DAY: begin
				if (is_dig) begin
					n = day_acc * 10 + dv;
					day_acc = (n > dtp_pkg::FIELD_MAX) ? dtp_pkg::FIELD_MAX : n;
				end else begin
					// Whatever closes the day is consumed, right or wrong.
					if (c != sep_reg) seps_good = 1'b0;
					field_at = FLD_MONTH;
				end
			end
			FLD_MONTH: begin
				if (is_dig) begin
					n = month_acc * 10 + dv;
					month_acc = (n > dtp_pkg::FIELD_MAX) ? dtp_pkg::FIELD_MAX : n;
				end else begin
					if (c != sep_reg) seps_good = 1'b0;
					field_at = FLD_YEAR;
				end
			end
			default: begin
				if (!year_done) begin
					if (is_dig) begin
						year_began = 1'b1;
						n = year_acc * 10 + dv;
						if (n > YEAR_MAX) begin
							year_over = 1'b1;
							n = YEAR_MAX;
						end
						year_acc = n;
					end else if (!year_began &&
					             (c inside {dtp_pkg::CHAR_PLUS, dtp_pkg::CHAR_MINUS})) begin
						year_began = 1'b1;
						year_neg = (c == dtp_pkg::CHAR_MINUS);
					end else begin
						// A second sign or any other non-digit ends the year.
						year_done = 1'b1;
					end
				end
			end
		endcase

		if (fin) begin
			ok = seps_good && field_at == FLD_YEAR && !year_over &&
				!(year_neg && year_acc != 0) &&
				month_acc >= 1 && month_acc <= 12 && day_acc >= 1;
			if (ok && day_acc > month_length(month_acc, year_acc)) ok = 1'b0;
			r.day   = day_acc[dtp_pkg::DAY_W-1:0];
			r.month = month_acc[dtp_pkg::DAY_W-1:0];
			r.year  = year_acc[dtp_pkg::YEAR_W-1:0];
			r.wday  = ok ? weekday_of(day_acc, month_acc, year_acc) : '0;
			r.ok    = ok;
			dates_due.push_back(r);

			field_at   = FLD_DAY;
			day_acc    = 0;
			month_acc  = 0;
			year_acc   = 0;
			seps_good  = 1'b1;
			year_over  = 1'b0;
			year_neg   = 1'b0;
			year_began = 1'b0;
			year_done  = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Request side. Called at a rising edge; returns at the edge where the
	// request is taken, or after a random gap behind it. valid stays high into
	// the next request unless a gap drops it: never lowered and raised at once.
	// ------------------------------------------------------------------------
	task automatic send_char(input char_t c, input logic fin);
		int gap;
		in_valid  <= 1'b1;
		text_char <= c;
		last_char <= fin;
		do @(posedge clk); while (in_stall);
		predict_date(c, fin);
		chars_sent++;
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sends the whole buffered text, marking the final character.
	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++) begin
			send_char(text_buf[i], i == text_buf.size() - 1);
		end
	endtask

	// Holds off new requests until every predicted date has come out, then
	// lets the pipeline settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (dates_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// The separator is only changed with the block empty.
	task automatic write_separator(input char_t v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sep_reg = v;
	endtask

	task automatic add_number(input int v, input int zeros);
		string s;
		s = $sformatf("%0d", v);
		repeat (zeros) text_buf.push_back(dtp_pkg::CHAR_ZERO);
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
	endtask

	task automatic add_string(input string s);
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
	endtask

	// Builds one random text. Most are well formed with random content so
	// that the year field and the calendar check are reached; the rest are
	// plain noise, wrong separators, early ends and oversized fields.
	task automatic build_date();
		int kind;
		int d, m, yr, r;
		kind = $urandom_range(0, 9);
		text_buf.delete();
		if (kind == 0) begin
			repeat ($urandom_range(1, 12)) begin
				text_buf.push_back(char_t'($urandom_range(0, 255)));
			end
			return;
		end

		d = $urandom_range(1, 31);
		m = $urandom_range(1, 12);
		if ($urandom_range(0, 7) == 0) begin
			// Around the end of February, where leap years matter.
			m = 2;
			d = $urandom_range(28, 30);
		end
		if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 150);
		if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 120);

		add_number(d, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
		text_buf.push_back((kind == 1) ? char_t'($urandom_range(0, 255)) : sep_reg);
		add_number(m, ($urandom_range(0, 3) == 0) ? 1 : 0);
		if (kind == 2) return;
		text_buf.push_back((kind == 3) ? char_t'($urandom_range(0, 255)) : sep_reg);

		r = $urandom_range(0, 9);
		if (r == 0) text_buf.push_back(dtp_pkg::CHAR_MINUS);
		else if (r == 1) text_buf.push_back(dtp_pkg::CHAR_PLUS);
		else if (r == 2) begin
			text_buf.push_back(dtp_pkg::CHAR_PLUS);
			text_buf.push_back(dtp_pkg::CHAR_MINUS);
		end

		r = $urandom_range(0, 9);
		if (r < 5) yr = $urandom_range(0, 9999);
		else if (r < 8) yr = 100 * $urandom_range(0, 99) +
			($urandom_range(0, 1) ? 0 : $urandom_range(0, 8));
		else if (r == 8) yr = $urandom_range(10000, 999999);
		else yr = -1;
		if (yr >= 0) add_number(yr, ($urandom_range(0, 5) == 0) ? 1 : 0);

		// Random trailing characters; once the year is ended, the parser ignores the rest.
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 3)) text_buf.push_back(char_t'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: random stall bursts while enabled.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every result taken is matched against the oldest pending date.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_date.day   = day_number;
			got_date.month = month_number;
			got_date.year  = year_number;
			got_date.wday  = week_day;
			got_date.ok    = date_valid;
			if (dates_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result with no date pending: d=%0d m=%0d y=%0d w=%0d ok=%0b",
						$realtime, got_date.day, got_date.month, got_date.year,
						got_date.wday, got_date.ok);
				end
			end else begin
				want_date = dates_due.pop_front();
				if (got_date != want_date) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: date differs: want d=%0d m=%0d y=%0d w=%0d ok=%0b",
							$realtime, want_date.day, want_date.month, want_date.year,
							want_date.wday, want_date.ok);
						$display("%0t:               got  d=%0d m=%0d y=%0d w=%0d ok=%0b",
							$realtime, got_date.day, got_date.month, got_date.year,
							got_date.wday, got_date.ok);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// A text that stops in the day field, and one with bytes 0 and 255 as the
	// separators and a negative year.
	task automatic test_incomplete_texts();
		text_buf.delete();
		add_string("7");
		send_text();
		text_buf.delete();
		text_buf.push_back(char_t'("1"));
		text_buf.push_back(8'h00);
		text_buf.push_back(char_t'("2"));
		text_buf.push_back(8'hFF);
		add_string("-3");
		send_text();
	endtask

	// Leap day in year zero written as minus zero, and a second sign that
	// closes the year before any digit.
	task automatic test_year_signs();
		text_buf.delete();
		add_string("29.2.-0");
		send_text();
		text_buf.delete();
		add_string("1.1.+-");
		send_text();
	endtask

	// A year with more digits than the block keeps.
	task automatic test_long_year();
		text_buf.delete();
		add_string("1.1.12345");
		send_text();
	endtask

	// Random texts under several separators, the extremes 0 and 255 among
	// them. Idling is switched on and off in stretches; the last setting
	// runs with no idling at all.
	task automatic test_random_dates();
		char_t seps[7];
		int    start;
		seps = '{dtp_pkg::SEP_RESET, 8'h00, 8'hFF, char_t'("/"), dtp_pkg::CHAR_MINUS,
			char_t'($urandom_range(0, 255)), dtp_pkg::SEP_RESET};
		for (int p = 0; p < 7; p++) begin
			write_separator(seps[p]);
			start = chars_sent;
			while (chars_sent - start < PHASE_CHARS) begin
				if (p == 6) begin
					gaps_on   = 1'b0;
					stalls_on = 1'b0;
				end else if ($urandom_range(0, 7) == 0) begin
					gaps_on   = $urandom_range(0, 3) != 0;
					stalls_on = $urandom_range(0, 3) != 0;
				end
				build_date();
				send_text();
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		test_incomplete_texts();
		test_year_signs();
		// Hold requests back once until every result is out.
		drain_results();
		test_long_year();
		test_random_dates();

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
